// ----- design/rcd_pkg.sv -----
package rcd_pkg;

    localparam int unsigned HDR_BYTES   = 9;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned OUT_TDATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD    = 8'd3;

    localparam logic [7:0] MAX_PAYLOAD_RST = 8'hFF;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_OVER_LIMIT = 3'd3,
        ST_MISMATCH   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [7:0] format_version;
        logic [7:0] max_payload;
    } rcd_cfg_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        packet_done;
        status_t     status;
        logic [15:0] session_id;
        logic [15:0] sequence_number;
        logic [7:0]  payload_length;
        logic [7:0]  header_flags;
    } rcd_result_t;

endpackage

// ----- design/rcd_parser.sv -----
module rcd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          rx_byte,
    input  logic                final_byte,
    input  rcd_pkg::rcd_cfg_t   cfg,
    output logic                res_push,
    output rcd_pkg::rcd_result_t res
);
    import rcd_pkg::*;

    localparam logic [POS_W-1:0] POS_MAGIC0  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_MAGIC1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_VERSION = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SESS_LO = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SESS_HI = POS_W'(4);
    localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(8);
    localparam logic [POS_W-1:0] POS_SAT     = {POS_W{1'b1}};

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      session_reg, session_next;
    logic [15:0]      sequence_reg, sequence_next;
    logic [7:0]       length_reg, length_next;
    logic [7:0]       flags_reg, flags_next;
    status_t          err_reg, err_next;
    logic             pass;
    logic [POS_W:0]   count;
    logic [POS_W-1:0] pay_index;
    status_t          status;

    assign pay_index = pos_reg - POS_W'(HDR_BYTES);
    assign count     = {1'b0, pos_reg} + (POS_W+1)'(1);

    always_comb
    begin
        session_next  = session_reg;
        sequence_next = sequence_reg;
        length_next   = length_reg;
        flags_next    = flags_reg;
        err_next      = err_reg;
        pass          = 1'b0;
        case (pos_reg)
            POS_MAGIC0:
            begin
                if (rx_byte != cfg.magic_first && err_reg == ST_OK)
                    err_next = ST_BAD_MAGIC;
            end
            POS_MAGIC1:
            begin
                if (rx_byte != cfg.magic_second && err_reg == ST_OK)
                    err_next = ST_BAD_MAGIC;
            end
            POS_VERSION:
            begin
                if (rx_byte != cfg.format_version && err_reg == ST_OK)
                    err_next = ST_BAD_MAGIC;
            end
            POS_SESS_LO: session_next[7:0]   = rx_byte;
            POS_SESS_HI: session_next[15:8]  = rx_byte;
            POS_SEQ_LO:  sequence_next[7:0]  = rx_byte;
            POS_SEQ_HI:  sequence_next[15:8] = rx_byte;
            POS_LENGTH:
            begin
                length_next = rx_byte;
                if (rx_byte > cfg.max_payload && err_reg == ST_OK)
                    err_next = ST_OVER_LIMIT;
            end
            POS_FLAGS:   flags_next = rx_byte;
            default:
            begin
                pass = (err_reg == ST_OK) && (pay_index < {1'b0, length_reg});
            end
        endcase

        pos_next = (pos_reg == POS_SAT) ? POS_SAT : count[POS_W-1:0];
    end

    always_comb
    begin
        if (pos_reg < POS_FLAGS)
            status = ST_SHORT;
        else if (err_next != ST_OK)
            status = err_next;
        else if (count != (POS_W+1)'(HDR_BYTES) + {2'b00, length_next})
            status = ST_MISMATCH;
        else
            status = ST_OK;
    end

    always_comb
    begin
        res_push            = in_fire && (final_byte || pass);
        res.payload_valid   = pass;
        res.payload_byte    = pass ? rx_byte : 8'd0;
        res.packet_done     = final_byte;
        res.status          = final_byte ? status : ST_OK;
        res.session_id      = final_byte ? session_next : 16'd0;
        res.sequence_number = final_byte ? sequence_next : 16'd0;
        res.payload_length  = final_byte ? length_next : 8'd0;
        res.header_flags    = final_byte ? flags_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            session_reg  <= '0;
            sequence_reg <= '0;
            length_reg   <= '0;
            flags_reg    <= '0;
            err_reg      <= ST_OK;
        end
        else if (in_fire)
        begin
            if (final_byte)
            begin
                pos_reg      <= '0;
                session_reg  <= '0;
                sequence_reg <= '0;
                length_reg   <= '0;
                flags_reg    <= '0;
                err_reg      <= ST_OK;
            end
            else
            begin
                pos_reg      <= pos_next;
                session_reg  <= session_next;
                sequence_reg <= sequence_next;
                length_reg   <= length_next;
                flags_reg    <= flags_next;
                err_reg      <= err_next;
            end
        end
    end

endmodule

// ----- design/radio_chunk_deframer_top.sv -----
// Each result is registered in the output register, or in the skid when the output stalls.
// Takes one byte per cycle while s_axis_tready is high; header parse and checks are a counter and compares.
// A two-entry output buffer (output register plus skid) keeps s_axis_tready registered.
// Reset (rst_n low, async): position, held header fields, error, buffers cleared;
// magic/version registers go to 0, max_payload to 255.
module radio_chunk_deframer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    input  logic                                s_axis_tlast,  // final_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [26:11] session_id,
    // [42:27] sequence_number, [50:43] payload_length, [58:51] header_flags
    output logic [rcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,  // packet_done
    output logic                                m_axis_tuser,  // payload_valid
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [7:0]                          cfg_data
);
    import rcd_pkg::*;

    rcd_cfg_t    cfg_reg;
    logic        in_fire;
    logic        res_push;
    rcd_result_t res;
    logic        out_valid_reg;
    rcd_result_t out_reg;
    logic        skid_valid_reg;
    rcd_result_t skid_reg;
    logic        out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_first    <= '0;
            cfg_reg.magic_second   <= '0;
            cfg_reg.format_version <= '0;
            cfg_reg.max_payload    <= MAX_PAYLOAD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAGIC_FIRST:    cfg_reg.magic_first    <= cfg_data;
                REG_MAGIC_SECOND:   cfg_reg.magic_second   <= cfg_data;
                REG_FORMAT_VERSION: cfg_reg.format_version <= cfg_data;
                REG_MAX_PAYLOAD:    cfg_reg.max_payload    <= cfg_data;
                default:            ;
            endcase
        end
    end

    rcd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .rx_byte    (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .cfg        (cfg_reg),
        .res_push   (res_push),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_push;
            end
        end
        else if (res_push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (res_push)
                out_reg <= res;
        end
        else if (res_push)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.payload_valid;
    assign m_axis_tlast  = out_reg.packet_done;
    assign m_axis_tdata  = {5'd0, out_reg.header_flags, out_reg.payload_length,
                            out_reg.sequence_number, out_reg.session_id,
                            out_reg.status, out_reg.payload_byte};

endmodule

// ----- design/rcd_checker.sv -----
module rcd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);
    import rcd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser || m_axis_tlast)
        else $error("result with neither payload nor packet end");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[63:8] == 56'd0)
        else $error("header fields set without packet end");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[10:8] <= ST_MISMATCH
            && m_axis_tdata[63:59] == 5'd0)
        else $error("bad status code");

    a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with output empty");

endmodule

bind radio_chunk_deframer_top rcd_checker u_rcd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
